/* src/arpt_pkg.sv */
// ----------------------------------------------------------------------------
// arpt_pkg
// Shared types and constants for the IPv4-to-MAC address table: request and
// result codes, the table entry layout and the two default entries.
// ----------------------------------------------------------------------------
package arpt_pkg;

   localparam int IP_W   = 32;
   localparam int MAC_W  = 48;
   localparam int IDX_W  = 7;
   localparam int STAT_W = 3;

   // request command codes
   typedef enum logic {
      CMD_LOOKUP = 1'b0,
      CMD_ADD    = 1'b1
   } cmd_type;

   // result status codes
   typedef enum logic [STAT_W-1:0] {
      ST_FOUND     = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_EXISTS    = 3'd2,
      ST_FULL      = 3'd3,
      ST_ADDED     = 3'd4
   } status_type;

   // one table entry as held in the memory
   typedef struct packed {
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
   } entry_type;

   // entries present after reset
   localparam logic [IP_W-1:0]  DEF0_IP  = 32'hC0A8_0101;
   localparam logic [MAC_W-1:0] DEF0_MAC = 48'hAABB_CCDD_EE01;
   localparam logic [IP_W-1:0]  DEF1_IP  = 32'hC0A8_0102;
   localparam logic [MAC_W-1:0] DEF1_MAC = 48'hAABB_CCDD_EE02;

endpackage

/* src/arpt_if.sv */
// ----------------------------------------------------------------------------
// arpt_if
// Valid/ready channels of the address table: the request channel and the
// result channel, each with a source and a sink view.
// ----------------------------------------------------------------------------

// request channel: command, address and MAC to store
interface arpt_req_if;
   logic                        valid;
   logic                        ready;
   logic                        cmd;
   logic [arpt_pkg::IP_W-1:0]   ip_addr;
   logic [arpt_pkg::MAC_W-1:0]  mac_in;

   modport source (output valid, output cmd, output ip_addr, output mac_in,
                   input ready);
   modport sink   (input valid, input cmd, input ip_addr, input mac_in,
                   output ready);
endinterface

// result channel: status, matched MAC and entry index
interface arpt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [arpt_pkg::STAT_W-1:0] status;
   logic [arpt_pkg::MAC_W-1:0]  mac_out;
   logic [arpt_pkg::IDX_W-1:0]  entry_index;

   modport source (output valid, output status, output mac_out,
                   output entry_index, input ready);
   modport sink   (input valid, input status, input mac_out,
                   input entry_index, output ready);
endinterface

/* src/arp_table_lookup_insert.sv */
// ----------------------------------------------------------------------------
// arp_table_lookup_insert
// IPv4-to-MAC address table with lookup and append. Entries sit in one
// synchronous memory that is scanned one entry per cycle in index order.
// ----------------------------------------------------------------------------
//
//   channel    | dir | payload                          | transfer when
//   -----------+-----+----------------------------------+-------------------
//   req_chan   | in  | cmd, ip_addr, mac_in             | valid && ready
//   rsp_chan   | out | status, mac_out, entry_index     | valid && ready
//
// After a transfer the request is scanned and its result goes to the result
// register: the scan reads one entry per cycle through the single memory
// read port, with registered read data, and stops early on a match. The
// block then returns to idle and takes the next request once the result
// is registered. After reset the block writes the two default entries, in
// states S_INIT0 and S_INIT1, during which no request is taken.
// The result sits in an output register; a new request is taken while an
// earlier result still waits, and the block stalls only in its final step
// when that register is still occupied.
//
module arp_table_lookup_insert #(
   parameter int TABLE_DEPTH = 128
) (
   input  logic               clock,
   input  logic               reset,
   arpt_req_if.sink           req_chan,
   arpt_rsp_if.source         rsp_chan
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [4:0] {
      S_INIT0  = 5'b00001,
      S_INIT1  = 5'b00010,
      S_IDLE   = 5'b00100,
      S_SCAN   = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   // table memory
   arpt_pkg::entry_type mem [TABLE_DEPTH];

   state_type                      state_ff, state_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [CW-1:0]                  issue_ff, issue_in;
   logic                           pend_vld_ff, pend_vld_in;
   logic [AW-1:0]                  pend_idx_ff, pend_idx_in;
   arpt_pkg::entry_type            rd_data_ff;

   logic                           cmd_ff;
   logic [arpt_pkg::IP_W-1:0]      ip_ff;
   logic [arpt_pkg::MAC_W-1:0]     mac_ff;

   logic                           hit_ff, hit_in;
   logic [AW-1:0]                  hit_idx_ff, hit_idx_in;
   logic [arpt_pkg::MAC_W-1:0]     hit_mac_ff, hit_mac_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   arpt_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [arpt_pkg::MAC_W-1:0]     rsp_mac_ff, rsp_mac_in;
   logic [arpt_pkg::IDX_W-1:0]     rsp_idx_ff, rsp_idx_in;

   logic                           rd_en;
   logic                           wr_en;
   logic [AW-1:0]                  wr_addr;
   arpt_pkg::entry_type            wr_data;
   logic                           req_xfer;
   logic                           out_free;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // control and result logic
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      pend_vld_in   = 1'b0;
      pend_idx_in   = pend_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_mac_in    = hit_mac_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_mac_in    = rsp_mac_ff;
      rsp_idx_in    = rsp_idx_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;

      unique case (state_ff)
         S_INIT0: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(0);
            wr_data  = '{ip: arpt_pkg::DEF0_IP, mac: arpt_pkg::DEF0_MAC};
            state_in = S_INIT1;
         end
         S_INIT1: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(1);
            wr_data  = '{ip: arpt_pkg::DEF1_IP, mac: arpt_pkg::DEF1_MAC};
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_xfer) begin
               issue_in = '0;
               hit_in   = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // compare the entry read last cycle, else issue the next read
            if (pend_vld_ff && (rd_data_ff.ip == ip_ff)) begin
               hit_in     = 1'b1;
               hit_idx_in = pend_idx_ff;
               hit_mac_in = rd_data_ff.mac;
               state_in   = S_FINISH;
            end else if (issue_ff < count_ff) begin
               rd_en       = 1'b1;
               pend_vld_in = 1'b1;
               pend_idx_in = issue_ff[AW-1:0];
               issue_in    = CW'(issue_ff + 1'b1);
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mac_in   = '0;
               rsp_idx_in   = '0;
               state_in     = S_IDLE;
               if (cmd_ff == arpt_pkg::CMD_LOOKUP) begin
                  if (hit_ff) begin
                     rsp_status_in = arpt_pkg::ST_FOUND;
                     rsp_mac_in    = hit_mac_ff;
                     rsp_idx_in    = arpt_pkg::IDX_W'(hit_idx_ff);
                  end else begin
                     rsp_status_in = arpt_pkg::ST_NOT_FOUND;
                  end
               end else if (hit_ff) begin
                  rsp_status_in = arpt_pkg::ST_EXISTS;
                  rsp_idx_in    = arpt_pkg::IDX_W'(hit_idx_ff);
               end else if (count_ff >= CW'(TABLE_DEPTH)) begin
                  rsp_status_in = arpt_pkg::ST_FULL;
               end else begin
                  // append at the end of the table
                  wr_en         = 1'b1;
                  wr_addr       = count_ff[AW-1:0];
                  wr_data       = '{ip: ip_ff, mac: mac_ff};
                  rsp_status_in = arpt_pkg::ST_ADDED;
                  rsp_idx_in    = arpt_pkg::IDX_W'(count_ff);
                  count_in      = CW'(count_ff + 1'b1);
               end
            end
         end
         default: begin
            state_in = S_INIT0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT0;
         count_ff     <= CW'(2);
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff <= req_chan.cmd;
         ip_ff  <= req_chan.ip_addr;
         mac_ff <= req_chan.mac_in;
      end
      issue_ff      <= issue_in;
      pend_idx_ff   <= pend_idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_mac_ff    <= hit_mac_in;
      rsp_status_ff <= rsp_status_in;
      rsp_mac_ff    <= rsp_mac_in;
      rsp_idx_ff    <= rsp_idx_in;
   end

   // memory write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // memory read port, registered data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[issue_ff[AW-1:0]];
      end
   end

   // result channel
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.mac_out     = rsp_mac_ff;
   assign rsp_chan.entry_index = rsp_idx_ff;

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the IPv4-to-MAC address table. Lookups and adds go
// in over the request channel; a local copy of the table predicts each
// status, MAC and index, and every result transfer is compared in order.
// ----------------------------------------------------------------------------
module testbench;

   localparam int DEPTH       = 128;
   localparam int QUIET_LIMIT = 4000;
   localparam int SETTLE      = DEPTH + 16;

   // one predicted result
   typedef struct {
      arpt_pkg::status_type            status;
      logic [arpt_pkg::MAC_W-1:0]      mac;
      logic [arpt_pkg::IDX_W-1:0]      index;
   } arp_result_type;

   logic clock = 1'b0;
   logic reset;

   arpt_req_if req_bus ();
   arpt_rsp_if rsp_bus ();

   arp_table_lookup_insert #(
      .TABLE_DEPTH (DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // local copy of the address table
   logic [arpt_pkg::IP_W-1:0]  shadow_ip  [DEPTH];
   logic [arpt_pkg::MAC_W-1:0] shadow_mac [DEPTH];
   int                         shadow_count;

   arp_result_type pending_results [$];
   int             error_count = 0;
   int             quiet_cycles = 0;
   int             tx_idle_pct = 0;
   int             rx_idle_pct = 0;

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // scan the shadow table and apply the request to it
   function automatic arp_result_type resolve_request(
      input arpt_pkg::cmd_type          cmd,
      input logic [arpt_pkg::IP_W-1:0]  ip,
      input logic [arpt_pkg::MAC_W-1:0] mac);
      arp_result_type res;
      int hit;
      hit = -1;
      for (int i = 0; i < shadow_count; i++) begin
         if (hit < 0 && shadow_ip[i] == ip) hit = i;
      end
      res.mac   = '0;
      res.index = '0;
      if (cmd == arpt_pkg::CMD_LOOKUP) begin
         if (hit >= 0) begin
            res.status = arpt_pkg::ST_FOUND;
            res.mac    = shadow_mac[hit];
            res.index  = hit[arpt_pkg::IDX_W-1:0];
         end else begin
            res.status = arpt_pkg::ST_NOT_FOUND;
         end
      end else if (hit >= 0) begin
         res.status = arpt_pkg::ST_EXISTS;
         res.index  = hit[arpt_pkg::IDX_W-1:0];
      end else if (shadow_count >= DEPTH) begin
         res.status = arpt_pkg::ST_FULL;
      end else begin
         shadow_ip[shadow_count]  = ip;
         shadow_mac[shadow_count] = mac;
         res.status = arpt_pkg::ST_ADDED;
         res.index  = shadow_count[arpt_pkg::IDX_W-1:0];
         shadow_count++;
      end
      return res;
   endfunction

   // drive one request, wait for its transfer and record the prediction
   task automatic send_request(input arpt_pkg::cmd_type          cmd,
                               input logic [arpt_pkg::IP_W-1:0]  ip,
                               input logic [arpt_pkg::MAC_W-1:0] mac);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.cmd     <= cmd;
      req_bus.ip_addr <= ip;
      req_bus.mac_in  <= mac;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pending_results.push_back(resolve_request(cmd, ip, mac));
   endtask

   // hold the sender off until every result has come back
   task automatic drain_pending();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [arpt_pkg::MAC_W-1:0] random_mac();
      return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
   endfunction

   // compare one result transfer with the oldest prediction
   task automatic check_result();
      arp_result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("result with no request outstanding");
      end else begin
         want = pending_results.pop_front();
         if (rsp_bus.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      rsp_bus.status, want.status));
         if (rsp_bus.mac_out !== want.mac)
            report_mismatch($sformatf("mac_out %h, expected %h",
                                      rsp_bus.mac_out, want.mac));
         if (rsp_bus.entry_index !== want.index)
            report_mismatch($sformatf("entry_index %0d, expected %0d",
                                      rsp_bus.entry_index, want.index));
      end
   endtask

   // result checking and receiver back-pressure
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         check_result();
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // lookups against the two entries present after reset
   task automatic test_default_entries();
      send_request(arpt_pkg::CMD_LOOKUP, arpt_pkg::DEF0_IP, '1);
      send_request(arpt_pkg::CMD_LOOKUP, arpt_pkg::DEF1_IP, 48'h5A5A_5A5A_5A5A);
      send_request(arpt_pkg::CMD_LOOKUP, 32'hC0A8_0103, '0);
      send_request(arpt_pkg::CMD_LOOKUP, '0, '0);
      send_request(arpt_pkg::CMD_LOOKUP, '1, '1);
   endtask

   // appends, duplicates and field extremes
   task automatic test_add_basics();
      send_request(arpt_pkg::CMD_ADD, '1, '1);
      send_request(arpt_pkg::CMD_ADD, '0, '0);
      send_request(arpt_pkg::CMD_ADD, arpt_pkg::DEF0_IP, 48'h1234_5678_9ABC);
      send_request(arpt_pkg::CMD_ADD, arpt_pkg::DEF1_IP, '0);
      send_request(arpt_pkg::CMD_ADD, '1, 48'h0000_0000_0001);
      send_request(arpt_pkg::CMD_LOOKUP, '1, '0);
      send_request(arpt_pkg::CMD_LOOKUP, '0, '1);
      send_request(arpt_pkg::CMD_ADD, 32'hAAAA_AAAA, 48'h5555_5555_5555);
      send_request(arpt_pkg::CMD_ADD, 32'h5555_5555, 48'hAAAA_AAAA_AAAA);
      send_request(arpt_pkg::CMD_LOOKUP, 32'hAAAA_AAAA, '0);
      send_request(arpt_pkg::CMD_LOOKUP, 32'h5555_5555, '0);
      send_request(arpt_pkg::CMD_LOOKUP, 32'hAAAA_AAAB, '0);
      send_request(arpt_pkg::CMD_LOOKUP, arpt_pkg::DEF0_IP, '0);
   endtask

   // random mix of hits, misses, new and repeated adds
   task automatic test_random_mix(input int count);
      int pick;
      int slot;
      logic [arpt_pkg::IP_W-1:0] ip;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         slot = $urandom_range(0, shadow_count - 1);
         if (pick < 38) begin
            send_request(arpt_pkg::CMD_LOOKUP, shadow_ip[slot], random_mac());
         end else if (pick < 47) begin
            ip = shadow_ip[slot] ^ (32'h1 << $urandom_range(0, 31));
            send_request(arpt_pkg::CMD_LOOKUP, ip, random_mac());
         end else if (pick < 55) begin
            send_request(arpt_pkg::CMD_LOOKUP, $urandom(), random_mac());
         end else if (pick < 77) begin
            send_request(arpt_pkg::CMD_ADD, $urandom(), random_mac());
         end else if (pick < 91) begin
            send_request(arpt_pkg::CMD_ADD, shadow_ip[slot], random_mac());
         end else begin
            ip = shadow_ip[slot] ^ (32'h1 << $urandom_range(0, 31));
            send_request(arpt_pkg::CMD_ADD, ip, random_mac());
         end
      end
   endtask

   // fill the table, then adds and lookups on a full table
   task automatic test_full_table();
      while (shadow_count < DEPTH) begin
         send_request(arpt_pkg::CMD_ADD, $urandom(), random_mac());
      end
      send_request(arpt_pkg::CMD_ADD, 32'hFFFF_FFFE, random_mac());
      send_request(arpt_pkg::CMD_ADD, arpt_pkg::DEF1_IP, random_mac());
      send_request(arpt_pkg::CMD_ADD, shadow_ip[DEPTH-1], random_mac());
      send_request(arpt_pkg::CMD_LOOKUP, shadow_ip[DEPTH-1], random_mac());
      send_request(arpt_pkg::CMD_LOOKUP, 32'hFFFF_FFFE, random_mac());
   endtask

   initial begin
      shadow_ip[0]  = arpt_pkg::DEF0_IP;
      shadow_mac[0] = arpt_pkg::DEF0_MAC;
      shadow_ip[1]  = arpt_pkg::DEF1_IP;
      shadow_mac[1] = arpt_pkg::DEF1_MAC;
      shadow_count  = 2;

      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.cmd     <= arpt_pkg::CMD_LOOKUP;
      req_bus.ip_addr <= '0;
      req_bus.mac_in  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver heavily
      tx_idle_pct = 16;
      rx_idle_pct = 54;
      test_default_entries();
      test_add_basics();
      drain_pending();
      test_random_mix(370);
      drain_pending();

      // sender idles heavily, receiver lightly
      tx_idle_pct = 54;
      rx_idle_pct = 16;
      test_random_mix(370);
      drain_pending();

      // no idling on either side
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_full_table();
      test_random_mix(370);
      req_bus.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
